// ===== src/lrr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared types and constants of the ranged LCG random number unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lrr_pkg;

  localparam int unsigned STATE_W  = 32;
  localparam int unsigned BOUND_W  = 16;
  localparam int unsigned DRAW_W   = 15;
  localparam int unsigned DRAW_LSB = 16;
  localparam int unsigned SPAN_W   = BOUND_W + 1;
  localparam int unsigned CNT_W    = $clog2(DRAW_W + 1);

  localparam logic [STATE_W-1:0] LCG_MUL   = 32'd1103515245;
  localparam logic [STATE_W-1:0] LCG_ADD   = 32'd12345;
  localparam logic [STATE_W-1:0] SEED_INIT = 32'd1;

  typedef enum logic [1:0] {
    ACT_RANGE = 2'd0,
    ACT_FRAC  = 2'd1,
    ACT_SEED  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADV,
    ST_DIV,
    ST_DONE
  } seq_state_t;

  // Commands from the sequencer to the generator state holder
  typedef struct packed {
    logic load_seed;
    logic mul;
    logic adv;
  } lcg_ctrl_t;

endpackage

`default_nettype wire

// ===== src/lcg_range_random_unit.sv =====
// ----------------------------------------------------------------------------
// lcg_range_random_unit
// 15-bit linear congruential random source with ranged and fraction draws.
// ----------------------------------------------------------------------------
// Steps: a reseed loads the generator state; a fraction draw goes through
//   multiply, advance and finish; a ranged draw with ordered bounds through
//   multiply, advance, 15 shift-subtract remainder steps and finish.
// Flow: one word at a time; a new word is taken only when the sequencer idles.
// Reset (rst_n low, synchronous): generator state returns to 1, sequencer
//   idles and any pending result word is dropped.
`default_nettype none

module lcg_range_random_unit
  import lrr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // seed_value[31:0], max_value[47:32], min_value[63:48]
  input  wire logic [1:0]  in_tuser,   // action[1:0]
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // value[15:0]
);

  seq_state_t state_r, state_nxt;

  logic [1:0]         act_r, act_nxt;
  logic [BOUND_W-1:0] max_r, max_nxt;
  logic [BOUND_W-1:0] min_r, min_nxt;
  logic [BOUND_W-1:0] result_r, result_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BOUND_W-1:0] out_data_r, out_data_nxt;

  logic               in_fire;
  logic [STATE_W-1:0] in_seed;
  logic [BOUND_W-1:0] in_max;
  logic [BOUND_W-1:0] in_min;
  logic               out_free;
  logic               span_ok;
  logic [SPAN_W-1:0]  span;

  lcg_ctrl_t          lcg_ctrl;
  logic [DRAW_W-1:0]  draw;
  logic               rem_start;
  logic               rem_done;
  logic [SPAN_W-1:0]  rem;

  // unpack the input word
  assign in_seed = in_tdata[31:0];
  assign in_max  = in_tdata[47:32];
  assign in_min  = in_tdata[63:48];

  // take a word only when the sequencer is idle
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // the output register frees up as its word is taken
  assign out_free = !out_valid_r || out_tready;

  // span of an ordered range, 1 .. 65536
  assign span_ok = (max_r >= min_r);
  assign span    = SPAN_W'({1'b0, max_r} - {1'b0, min_r} + 1'b1);

  lrr_lcg u_lcg (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (lcg_ctrl),
    .seed_i (in_seed),
    .draw_o (draw)
  );

  lrr_rem u_rem (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (rem_start),
    .dividend_i (draw),
    .divisor_i  (span),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    act_nxt            = act_r;
    max_nxt            = max_r;
    min_nxt            = min_r;
    result_nxt         = result_r;
    out_valid_nxt      = out_valid_r && !out_tready;
    out_data_nxt       = out_data_r;
    lcg_ctrl.load_seed = 1'b0;
    lcg_ctrl.mul       = 1'b0;
    lcg_ctrl.adv       = 1'b0;
    rem_start          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          act_nxt = in_tuser;
          max_nxt = in_max;
          min_nxt = in_min;
          case (in_tuser)
            ACT_SEED: begin
              lcg_ctrl.load_seed = 1'b1;
            end
            ACT_RANGE, ACT_FRAC: begin
              state_nxt = ST_MUL;
            end
            default: begin
              // unused code: drop the word
            end
          endcase
        end
      end
      ST_MUL: begin
        lcg_ctrl.mul = 1'b1;
        state_nxt    = ST_ADV;
      end
      ST_ADV: begin
        // advance the state and pick the result path
        lcg_ctrl.adv = 1'b1;
        if (act_r == ACT_FRAC) begin
          result_nxt = {1'b0, draw};
          state_nxt  = ST_DONE;
        end else if (span_ok) begin
          rem_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          // inverted bounds: add the draw unreduced
          result_nxt = BOUND_W'(min_r + {1'b0, draw});
          state_nxt  = ST_DONE;
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          result_nxt = BOUND_W'(min_r + rem[BOUND_W-1:0]);
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    max_r      <= max_nxt;
    min_r      <= min_nxt;
    result_r   <= result_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // the remainder unit only finishes while the sequencer waits for it
  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == ST_DIV))
    else $error("remainder finished outside its wait state");

  // a finished remainder is always below the span
  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (rem < span))
    else $error("remainder not reduced below span");

  // a fraction result never sets its top bit
  a_frac_top_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && (act_r == ACT_FRAC)) |-> (result_r[BOUND_W-1] == 1'b0))
    else $error("fraction result has its top bit set");

  // an accepted draw starts the multiply next cycle
  a_draw_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ((in_tuser == ACT_RANGE) || (in_tuser == ACT_FRAC)))
      |=> (state_r == ST_MUL))
    else $error("accepted draw did not start the multiply");

endmodule

`default_nettype wire

// ===== src/lrr_lcg.sv =====
// ----------------------------------------------------------------------------
// lrr_lcg
// Generator state with its multiplier and increment, stepped by a multiply command and then an advance command.
// ----------------------------------------------------------------------------
`default_nettype none

module lrr_lcg
  import lrr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lcg_ctrl_t          ctrl_i,
  input  wire logic [STATE_W-1:0] seed_i,
  output logic      [DRAW_W-1:0]  draw_o
);

  logic [STATE_W-1:0] state_r, state_nxt;
  logic [STATE_W-1:0] product_r, product_nxt;
  logic [STATE_W-1:0] sum;

  assign product_nxt = state_r * LCG_MUL;
  assign sum         = product_r + LCG_ADD;
  // new draw, seen in the cycle the state advances
  assign draw_o      = sum[DRAW_LSB +: DRAW_W];

  always_comb begin
    state_nxt = state_r;
    if (ctrl_i.load_seed) begin
      state_nxt = seed_i;
    end else if (ctrl_i.adv) begin
      state_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEED_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.mul) begin
      product_r <= product_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/lrr_rem.sv =====
// ----------------------------------------------------------------------------
// lrr_rem
// Restoring shift-subtract remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lrr_rem
  import lrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start_i,
  input  wire logic [DRAW_W-1:0] dividend_i,
  input  wire logic [SPAN_W-1:0] divisor_i,
  output logic                   done_o,
  output logic      [SPAN_W-1:0] rem_o
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DRAW_W-1:0] quo_r, quo_nxt;
  logic [SPAN_W-1:0] div_r, div_nxt;
  logic [SPAN_W-1:0] rem_r, rem_nxt;
  logic [SPAN_W:0]   shifted;

  // partial remainder stays below the divisor, so one more bit fits
  assign shifted = {rem_r, quo_r[DRAW_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DRAW_W);
      quo_nxt  = dividend_i;
      div_nxt  = divisor_i;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DRAW_W-2:0], 1'b0};
      if (shifted >= {1'b0, div_r}) begin
        rem_nxt = SPAN_W'(shifted - {1'b0, div_r});
      end else begin
        rem_nxt = SPAN_W'(shifted);
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

endmodule

`default_nettype wire
